@@ hw/rtl/ordered_list_engine_assert.svh @@
// Assertion macros for the ordered list engine.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define OLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ole: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ole: next-cycle check failed");

`endif

@@ hw/rtl/ole_pkg.sv @@
// Shared types and constants of the ordered list engine.
// No dependencies.
package ole_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 7;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;

  // Input request payload
  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [VAL_W-1:0] data_value;
    logic [POS_W-1:0]        position;
  } ole_in_t;

  // Result payload
  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] removed_value;
    logic [IDX_W-1:0]        found_index;
    logic [CNT_W-1:0]        item_count;
    logic                    is_empty;
  } ole_out_t;

  // Free pool strobes: take hands out a slot, put returns one
  typedef struct packed {
    logic take;
    logic put;
  } ole_pool_ctl_t;

  // Node memory field write enables
  typedef struct packed {
    logic wr_value;
    logic wr_next;
    logic wr_prev;
  } ole_wr_ctl_t;

endpackage

@@ hw/rtl/ole_stream_if.sv @@
// Valid/ready stream channel carrying one payload of type T.
// No dependencies; the payload type is set where the channel is instantiated.
interface ole_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/ole_node_ram.sv @@
// Node memory: value, next link and prev link of every slot in one word.
// One write port with per-field enables, one read port with registered data.
// Depends on ole_pkg.
module ole_node_ram import ole_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  ole_wr_ctl_t              wr_ctl,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  logic [VAL_W-1:0]         wr_val,
  input  logic [$clog2(CAPACITY)-1:0] wr_nxt,
  input  logic [$clog2(CAPACITY)-1:0] wr_prv,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic [VAL_W-1:0]         rd_val,
  output logic [$clog2(CAPACITY)-1:0] rd_nxt,
  output logic [$clog2(CAPACITY)-1:0] rd_prv
);

  localparam int SW     = $clog2(CAPACITY);
  localparam int NXT_LO = VAL_W;
  localparam int PRV_LO = VAL_W + SW;
  localparam int NW     = VAL_W + 2 * SW;

  logic [NW-1:0] mem_r [CAPACITY];
  logic [NW-1:0] rd_data_r;

  // Field-masked write, read-first registered read
  always_ff @(posedge clk) begin
    if (wr_ctl.wr_value) mem_r[wr_addr][VAL_W-1:0]   <= wr_val;
    if (wr_ctl.wr_next)  mem_r[wr_addr][NXT_LO +: SW] <= wr_nxt;
    if (wr_ctl.wr_prev)  mem_r[wr_addr][PRV_LO +: SW] <= wr_prv;
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_val = rd_data_r[VAL_W-1:0];
  assign rd_nxt = rd_data_r[NXT_LO +: SW];
  assign rd_prv = rd_data_r[PRV_LO +: SW];

endmodule

@@ hw/rtl/ole_free_pool.sv @@
// Free slot pool: a stack memory of returned slots plus a high-water counter
// for slots never handed out. Allocated slot is valid the cycle after take.
// Depends on ole_pkg.
module ole_free_pool import ole_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ole_pool_ctl_t               ctl,
  input  logic [$clog2(CAPACITY)-1:0] rel_slot,
  output logic [$clog2(CAPACITY)-1:0] alloc_slot
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [SW-1:0] mem_r [CAPACITY];
  logic [CW-1:0] top_r;
  logic [CW-1:0] hwm_r;
  logic          from_stack_r;
  logic [SW-1:0] stack_rd_r;
  logic [SW-1:0] hwm_slot_r;
  logic [CW-1:0] top_dec;

  assign top_dec = top_r - CW'(1);

  // Stack memory: push at top, pop reads the entry below top
  always_ff @(posedge clk) begin
    if (ctl.put) mem_r[top_r[SW-1:0]] <= rel_slot;
    if (ctl.take) begin
      stack_rd_r <= mem_r[top_dec[SW-1:0]];
      hwm_slot_r <= hwm_r[SW-1:0];
    end
  end

  // Stack depth and high-water mark; take and put never coincide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r        <= '0;
      hwm_r        <= '0;
      from_stack_r <= 1'b0;
    end else if (ctl.take) begin
      if (top_r != '0) begin
        top_r        <= top_dec;
        from_stack_r <= 1'b1;
      end else begin
        hwm_r        <= hwm_r + CW'(1);
        from_stack_r <= 1'b0;
      end
    end else if (ctl.put) begin
      top_r <= top_r + CW'(1);
    end
  end

  assign alloc_slot = from_stack_r ? stack_rd_r : hwm_slot_r;

endmodule

@@ hw/rtl/ole_ctrl.sv @@
// Sequencer of the ordered list engine: walks links through the node memory,
// issues link writes and slot alloc/free, and builds one result per request.
// Depends on ole_pkg.
module ole_ctrl import ole_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  ole_in_t                     in_data,
  output logic                        in_ready,
  output logic                        res_valid,
  output ole_out_t                    res_data,
  input  logic                        res_ready,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  logic [VAL_W-1:0]            rd_val,
  input  logic [$clog2(CAPACITY)-1:0] rd_nxt,
  input  logic [$clog2(CAPACITY)-1:0] rd_prv,
  output ole_wr_ctl_t                 wr_ctl,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  output logic [VAL_W-1:0]            wr_val,
  output logic [$clog2(CAPACITY)-1:0] wr_nxt,
  output logic [$clog2(CAPACITY)-1:0] wr_prv,
  output ole_pool_ctl_t               pool_ctl,
  output logic [$clog2(CAPACITY)-1:0] rel_slot,
  input  logic [$clog2(CAPACITY)-1:0] alloc_slot
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int XW = (SW > IDX_W) ? SW : IDX_W;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_REM_FRONT = 3'd1;
  localparam logic [2:0] OP_REM_BACK  = 3'd2;
  localparam logic [2:0] OP_REM_VALUE = 3'd3;
  localparam logic [2:0] OP_SEARCH    = 3'd4;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_WALK    = 4'd1;
  localparam logic [3:0] S_INS_NEW = 4'd2;
  localparam logic [3:0] S_INS_L1  = 4'd3;
  localparam logic [3:0] S_INS_L2  = 4'd4;
  localparam logic [3:0] S_REM_RD  = 4'd5;
  localparam logic [3:0] S_SRCH    = 4'd6;
  localparam logic [3:0] S_RV_L1   = 4'd7;
  localparam logic [3:0] S_RV_L2   = 4'd8;
  localparam logic [3:0] S_PUSH    = 4'd9;

  // Where an insert lands
  localparam logic [1:0] K_EMPTY = 2'd0;
  localparam logic [1:0] K_FRONT = 2'd1;
  localparam logic [1:0] K_BACK  = 2'd2;
  localparam logic [1:0] K_MID   = 2'd3;

  logic [3:0]       state_r,  state_nxt;
  logic [SW-1:0]    head_r,   head_nxt;
  logic [SW-1:0]    tail_r,   tail_nxt;
  logic [CW-1:0]    count_r,  count_nxt;
  logic [2:0]       op_r,     op_nxt;
  logic [VAL_W-1:0] val_r,    val_nxt;
  logic [SW-1:0]    pos_r,    pos_nxt;
  logic [1:0]       kind_r,   kind_nxt;
  logic [SW-1:0]    idx_r,    idx_nxt;
  logic [SW-1:0]    cur_r,    cur_nxt;
  logic [SW-1:0]    before_r, before_nxt;
  logic [SW-1:0]    after_r,  after_nxt;
  ole_out_t         res_r,    res_nxt;

  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] cnt_x;
  logic          full;
  logic          idx_is_last;
  logic          ins_done;

  function automatic ole_out_t mk_res(input logic ok, input logic [VAL_W-1:0] removed,
                                      input logic [SW-1:0] idx, input logic [CW-1:0] cnt);
    ole_out_t      r;
    logic [XW-1:0] ix;
    logic [PW-1:0] cx;
    ix              = XW'(idx);
    cx              = PW'(cnt);
    r.ok            = ok;
    r.removed_value = removed;
    r.found_index   = ix[IDX_W-1:0];
    r.item_count    = cx[CNT_W-1:0];
    r.is_empty      = (cnt == '0);
    return r;
  endfunction

  assign count_inc   = count_r + CW'(1);
  assign count_dec   = count_r - CW'(1);
  assign pos_x       = PW'(in_data.position);
  assign cnt_x       = PW'(count_r);
  assign full        = (count_r == CW'(CAPACITY));
  assign idx_is_last = (CW'(idx_r) == count_dec);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_PUSH);
  assign res_data  = res_r;

  // Sequencer; memory writes land before the next request can read them
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    kind_nxt   = kind_r;
    idx_nxt    = idx_r;
    cur_nxt    = cur_r;
    before_nxt = before_r;
    after_nxt  = after_r;
    res_nxt    = res_r;
    rd_addr    = rd_nxt;
    wr_ctl     = '0;
    wr_addr    = '0;
    wr_val     = val_r;
    wr_nxt     = '0;
    wr_prv     = '0;
    pool_ctl   = '0;
    rel_slot   = cur_r;
    ins_done   = 1'b0;

    case (state_r)
      S_IDLE: begin
        rd_addr = (in_data.opcode == OP_REM_BACK) ? tail_r : head_r;
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          val_nxt   = in_data.data_value;
          pos_nxt   = pos_x[SW-1:0];
          cur_nxt   = head_r;
          idx_nxt   = '0;
          state_nxt = S_PUSH;
          res_nxt   = mk_res(1'b0, '0, '0, count_r);
          case (in_data.opcode)
            OP_INSERT: begin
              if (!(pos_x > cnt_x) && !full) begin
                pool_ctl.take = 1'b1;
                if (count_r == '0) begin
                  kind_nxt  = K_EMPTY;
                  state_nxt = S_INS_NEW;
                end else if (pos_x == '0) begin
                  kind_nxt  = K_FRONT;
                  state_nxt = S_INS_NEW;
                end else if (pos_x == cnt_x) begin
                  kind_nxt  = K_BACK;
                  state_nxt = S_INS_NEW;
                end else begin
                  kind_nxt  = K_MID;
                  state_nxt = S_WALK;
                end
              end
            end
            OP_REM_FRONT, OP_REM_BACK: begin
              if (count_r != '0) state_nxt = S_REM_RD;
            end
            OP_REM_VALUE, OP_SEARCH: begin
              if (count_r != '0) state_nxt = S_SRCH;
            end
            default: ;
          endcase
        end
      end

      // One link per cycle until the slot at the insert position is in hand
      S_WALK: begin
        if (idx_r == pos_r) begin
          before_nxt = rd_prv;
          state_nxt  = S_INS_NEW;
        end else begin
          cur_nxt = rd_nxt;
          idx_nxt = idx_r + SW'(1);
        end
      end

      S_INS_NEW: begin
        wr_ctl  = '{wr_value: 1'b1, wr_next: 1'b1, wr_prev: 1'b1};
        wr_addr = alloc_slot;
        wr_nxt  = (kind_r == K_FRONT) ? head_r : cur_r;
        wr_prv  = (kind_r == K_BACK) ? tail_r : before_r;
        if (kind_r == K_EMPTY) ins_done = 1'b1;
        else state_nxt = S_INS_L1;
      end

      S_INS_L1: begin
        case (kind_r)
          K_FRONT: begin
            wr_ctl.wr_prev = 1'b1;
            wr_addr        = head_r;
            wr_prv         = alloc_slot;
          end
          K_BACK: begin
            wr_ctl.wr_next = 1'b1;
            wr_addr        = tail_r;
            wr_nxt         = alloc_slot;
          end
          default: begin
            wr_ctl.wr_next = 1'b1;
            wr_addr        = before_r;
            wr_nxt         = alloc_slot;
          end
        endcase
        if (kind_r == K_MID) state_nxt = S_INS_L2;
        else ins_done = 1'b1;
      end

      S_INS_L2: begin
        wr_ctl.wr_prev = 1'b1;
        wr_addr        = cur_r;
        wr_prv         = alloc_slot;
        ins_done       = 1'b1;
      end

      // End removal: node word of head or tail is on the read port
      S_REM_RD: begin
        pool_ctl.put = 1'b1;
        rel_slot     = (op_r == OP_REM_BACK) ? tail_r : head_r;
        if (count_r == CW'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else if (op_r == OP_REM_BACK) begin
          tail_nxt = rd_prv;
        end else begin
          head_nxt = rd_nxt;
        end
        count_nxt = count_dec;
        res_nxt   = mk_res(1'b1, rd_val, '0, count_dec);
        state_nxt = S_PUSH;
      end

      // Value scan from the head, one node per cycle
      S_SRCH: begin
        if (rd_val == val_r) begin
          if (op_r == OP_SEARCH) begin
            res_nxt   = mk_res(1'b1, '0, idx_r, count_r);
            state_nxt = S_PUSH;
          end else begin
            pool_ctl.put = 1'b1;
            if (idx_r == '0) begin
              if (count_r == CW'(1)) begin
                head_nxt = '0;
                tail_nxt = '0;
              end else begin
                head_nxt = rd_nxt;
              end
              count_nxt = count_dec;
              res_nxt   = mk_res(1'b1, '0, '0, count_dec);
              state_nxt = S_PUSH;
            end else if (idx_is_last) begin
              tail_nxt  = rd_prv;
              count_nxt = count_dec;
              res_nxt   = mk_res(1'b1, '0, '0, count_dec);
              state_nxt = S_PUSH;
            end else begin
              before_nxt = rd_prv;
              after_nxt  = rd_nxt;
              state_nxt  = S_RV_L1;
            end
          end
        end else if (idx_is_last) begin
          state_nxt = S_PUSH;
        end else begin
          cur_nxt = rd_nxt;
          idx_nxt = idx_r + SW'(1);
        end
      end

      // Unlink an inner node
      S_RV_L1: begin
        wr_ctl.wr_next = 1'b1;
        wr_addr        = before_r;
        wr_nxt         = after_r;
        state_nxt      = S_RV_L2;
      end

      S_RV_L2: begin
        wr_ctl.wr_prev = 1'b1;
        wr_addr        = after_r;
        wr_prv         = before_r;
        count_nxt      = count_dec;
        res_nxt        = mk_res(1'b1, '0, '0, count_dec);
        state_nxt      = S_PUSH;
      end

      S_PUSH: begin
        if (res_ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // Insert completion: head/tail update and count
    if (ins_done) begin
      case (kind_r)
        K_EMPTY: begin
          head_nxt = alloc_slot;
          tail_nxt = alloc_slot;
        end
        K_FRONT: head_nxt = alloc_slot;
        K_BACK:  tail_nxt = alloc_slot;
        default: ;
      endcase
      count_nxt = count_inc;
      res_nxt   = mk_res(1'b1, '0, '0, count_inc);
      state_nxt = S_PUSH;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Request payload and walk registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    kind_r   <= kind_nxt;
    idx_r    <= idx_nxt;
    cur_r    <= cur_nxt;
    before_r <= before_nxt;
    after_r  <= after_nxt;
    res_r    <= res_nxt;
  end

endmodule

@@ hw/rtl/ordered_list_engine.sv @@
// ordered_list_engine: bounded ordered list in a linked node memory. Depends on
// ole_pkg, ole_stream_if, ole_node_ram, ole_free_pool, ole_ctrl, assert macros.
// One request in flight; the next is accepted in the cycle after its result is registered.
// Sync reset clears control; memories are not cleared.
`include "ordered_list_engine_assert.svh"

module ordered_list_engine import ole_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ole_stream_if.sink   in_req,
  ole_stream_if.source out_rsp
);

  localparam int SW = $clog2(CAPACITY);

  logic          ctrl_in_ready;
  logic          res_valid;
  logic          res_ready;
  ole_out_t      res_data;
  logic [SW-1:0] rd_addr;
  logic [VAL_W-1:0] rd_val;
  logic [SW-1:0] rd_nxt;
  logic [SW-1:0] rd_prv;
  ole_wr_ctl_t   wr_ctl;
  logic [SW-1:0] wr_addr;
  logic [VAL_W-1:0] wr_val;
  logic [SW-1:0] wr_nxt;
  logic [SW-1:0] wr_prv;
  ole_pool_ctl_t pool_ctl;
  logic [SW-1:0] rel_slot;
  logic [SW-1:0] alloc_slot;
  ole_in_t       in_data;

  logic          out_valid_r;
  ole_out_t      out_data_r;

  assign in_data      = in_req.data;
  assign in_req.ready = ctrl_in_ready;

  ole_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_data    (in_data),
    .in_ready   (ctrl_in_ready),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .res_ready  (res_ready),
    .rd_addr    (rd_addr),
    .rd_val     (rd_val),
    .rd_nxt     (rd_nxt),
    .rd_prv     (rd_prv),
    .wr_ctl     (wr_ctl),
    .wr_addr    (wr_addr),
    .wr_val     (wr_val),
    .wr_nxt     (wr_nxt),
    .wr_prv     (wr_prv),
    .pool_ctl   (pool_ctl),
    .rel_slot   (rel_slot),
    .alloc_slot (alloc_slot)
  );

  ole_node_ram #(.CAPACITY(CAPACITY)) u_node_ram (
    .clk     (clk),
    .wr_ctl  (wr_ctl),
    .wr_addr (wr_addr),
    .wr_val  (wr_val),
    .wr_nxt  (wr_nxt),
    .wr_prv  (wr_prv),
    .rd_addr (rd_addr),
    .rd_val  (rd_val),
    .rd_nxt  (rd_nxt),
    .rd_prv  (rd_prv)
  );

  ole_free_pool #(.CAPACITY(CAPACITY)) u_free_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pool_ctl),
    .rel_slot   (rel_slot),
    .alloc_slot (alloc_slot)
  );

  // Output register: decouples result delivery from the next request
  assign res_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data_r <= res_data;
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  // Checks
  `OLE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_req.valid && in_req.ready, !in_req.ready)
  `OLE_ASSERT_NEXT(a_result_held, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_data))
  `OLE_ASSERT_NEXT(a_result_loaded, clk, rst_n, res_valid && res_ready, out_rsp.valid && out_rsp.data == $past(res_data))
  `OLE_ASSERT_SAME(a_no_accept_pending, clk, rst_n, res_valid, !in_req.ready)

endmodule

@@ sim/tb.sv @@
// Testbench for ordered_list_engine: directed and random list requests, checked
// against a queue-based prediction of the list. Needs ole_pkg, ole_stream_if and the RTL.
`timescale 1ns / 1ps

module tb;
  import ole_pkg::*;

  // Opcodes of a list request
  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_POP_FRONT = 3'd1,
    OP_POP_BACK  = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_SEARCH    = 3'd4,
    OP_RSVD5     = 3'd5,
    OP_RSVD6     = 3'd6,
    OP_RSVD7     = 3'd7
  } list_op_e;

  localparam int SETTLE_CYCLES = CAPACITY_DEF + 10;
  localparam int MAX_SHOWN     = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ole_stream_if #(.T(ole_in_t))  req_if ();
  ole_stream_if #(.T(ole_out_t)) rsp_if ();

  ordered_list_engine #(.CAPACITY(CAPACITY_DEF)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  // Predicted list contents, front first
  logic signed [VAL_W-1:0] list_model[$];
  ole_out_t                expected_results[$];

  int mismatch_count  = 0;
  bit no_idle         = 1'b0;
  int rx_hold_request = 0;
  int rx_hold_left    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
  end

  // Run limit, well above the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Apply one request to the predicted list and return the result it should give
  function automatic ole_out_t predict_list_op(ole_in_t req);
    ole_out_t rsp;
    int       hit;
    rsp = '0;
    hit = -1;
    case (req.opcode)
      OP_INSERT: begin
        if (int'(req.position) <= list_model.size() && list_model.size() < CAPACITY_DEF) begin
          list_model.insert(int'(req.position), req.data_value);
          rsp.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (list_model.size() != 0) begin
          rsp.removed_value = list_model.pop_front();
          rsp.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (list_model.size() != 0) begin
          rsp.removed_value = list_model.pop_back();
          rsp.ok = 1'b1;
        end
      end
      OP_REMOVE, OP_SEARCH: begin
        foreach (list_model[i])
          if (hit < 0 && list_model[i] == req.data_value) hit = i;
        if (hit >= 0) begin
          rsp.ok = 1'b1;
          if (req.opcode == OP_REMOVE) list_model.delete(hit);
          else rsp.found_index = hit[IDX_W-1:0];
        end
      end
      default: ;  // unknown opcode: no change, ok stays low
    endcase
    rsp.item_count = CNT_W'(list_model.size());
    rsp.is_empty   = (list_model.size() == 0);
    return rsp;
  endfunction

  function automatic ole_in_t make_req(list_op_e op, logic signed [VAL_W-1:0] value, int pos);
    ole_in_t req;
    req.opcode     = op;
    req.data_value = value;
    req.position   = pos[POS_W-1:0];
    return req;
  endfunction

  // Random request; inserts are favored while the list is below fill_target
  function automatic ole_in_t make_random_req(int fill_target);
    int       count;
    int       ins_weight;
    int       roll;
    list_op_e op;
    logic signed [VAL_W-1:0] value;
    int       pos;
    count      = list_model.size();
    ins_weight = (count < fill_target) ? 60 : 25;
    roll       = $urandom_range(99);
    if (roll < 3) op = list_op_e'($urandom_range(5, 7));
    else begin
      roll = $urandom_range(99);
      if (roll < ins_weight) op = OP_INSERT;
      else case ($urandom_range(3))
        0:       op = OP_POP_FRONT;
        1:       op = OP_POP_BACK;
        2:       op = OP_REMOVE;
        default: op = OP_SEARCH;
      endcase
    end
    // values: mostly ones already stored or from a small pool, so matches are common
    roll = $urandom_range(99);
    if (roll < 40 && count > 0) value = list_model[$urandom_range(count - 1)];
    else if (roll < 80) value = $signed($urandom_range(16)) - 8;
    else if (roll < 83) value = 32'sh8000_0000;
    else if (roll < 86) value = 32'sh7FFF_FFFF;
    else value = $urandom;
    // positions: mostly legal, with the ends and out-of-range values mixed in
    roll = $urandom_range(99);
    if (op != OP_INSERT || roll < 8) pos = $urandom_range(127);
    else if (roll < 20) pos = 0;
    else if (roll < 32) pos = count;
    else pos = $urandom_range(count);
    return make_req(op, value, pos);
  endfunction

  task automatic log_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) log_failure($sformatf("%s expected %0h got %0h", field, want, got));
  endtask

  // Send one request; valid stays high afterwards so the next one can follow at once
  task automatic send_request(ole_in_t req);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 10) begin
      gap = $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    do @(posedge clk); while (!req_if.ready);
    expected_results.push_back(predict_list_op(req));
  endtask

  task automatic idle_input();
    @(negedge clk);
    req_if.valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    idle_input();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result receiver: random stalls unless no_idle is set, or a counted hold when one is requested
  always @(negedge clk) begin
    if (rx_hold_request != 0) begin
      rx_hold_left    = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      rx_hold_left--;
    end else if (no_idle) begin
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= 10);
    end
  end

  // Result checker: each accepted result against the oldest prediction
  always @(posedge clk) begin
    ole_out_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        log_failure($sformatf("result %h with nothing outstanding", rsp_if.data));
      end else begin
        want = expected_results.pop_front();
        check_field("ok", 32'(want.ok), 32'(rsp_if.data.ok));
        check_field("removed_value", want.removed_value, rsp_if.data.removed_value);
        check_field("found_index", 32'(want.found_index), 32'(rsp_if.data.found_index));
        check_field("item_count", 32'(want.item_count), 32'(rsp_if.data.item_count));
        check_field("is_empty", 32'(want.is_empty), 32'(rsp_if.data.is_empty));
      end
    end
  end

  // Empty-list failures, bad positions, ends of the value range, unknown opcodes
  task automatic test_edge_cases();
    send_request(make_req(OP_POP_FRONT, 0, 0));
    send_request(make_req(OP_POP_BACK, 0, 0));
    send_request(make_req(OP_REMOVE, 5, 0));
    send_request(make_req(OP_SEARCH, 5, 0));
    send_request(make_req(OP_INSERT, 7, 1));             // past the end of an empty list
    send_request(make_req(OP_INSERT, 32'sh8000_0000, 0));
    send_request(make_req(OP_INSERT, 32'sh7FFF_FFFF, 1)); // at the back
    send_request(make_req(OP_INSERT, 0, 1));              // in the middle
    send_request(make_req(OP_INSERT, -1, 0));             // at the front
    send_request(make_req(OP_INSERT, 0, 2));              // duplicate value
    send_request(make_req(OP_INSERT, 9, 127));
    send_request(make_req(OP_INSERT, 9, 6));              // one past the count
    send_request(make_req(OP_SEARCH, 32'sh7FFF_FFFF, 0));
    send_request(make_req(OP_SEARCH, 0, 0));              // first of two matches
    send_request(make_req(OP_SEARCH, 123, 0));
    send_request(make_req(OP_REMOVE, 0, 0));              // inner unlink
    send_request(make_req(OP_REMOVE, -1, 0));             // front
    send_request(make_req(OP_REMOVE, 32'sh7FFF_FFFF, 0)); // back
    send_request(make_req(OP_REMOVE, 77, 0));
    send_request(make_req(OP_RSVD5, -1, 127));
    send_request(make_req(OP_RSVD6, -1, 127));
    send_request(make_req(OP_RSVD7, -1, 127));
    send_request(make_req(OP_POP_BACK, 0, 0));
    send_request(make_req(OP_POP_FRONT, 0, 0));           // list becomes empty
    send_request(make_req(OP_INSERT, 32'sh5555_AAAA, 0));
    send_request(make_req(OP_POP_BACK, 0, 0));
  endtask

  // Fill to capacity, hit the full-store failure and the last index, then empty it
  task automatic test_full_store();
    for (int i = 0; i < CAPACITY_DEF; i++)
      send_request(make_req(OP_INSERT, i * 3 - 90, $urandom_range(list_model.size())));
    send_request(make_req(OP_INSERT, 1, 0));
    send_request(make_req(OP_INSERT, 1, CAPACITY_DEF));
    send_request(make_req(OP_SEARCH, list_model[CAPACITY_DEF - 1], 0));
    for (int i = 0; i < CAPACITY_DEF; i++)
      send_request(make_req(list_op_e'((i % 2) ? OP_POP_BACK : OP_POP_FRONT), 0, 0));
  endtask

  // Random mix, fill target moving so the list sweeps from empty to full
  task automatic test_random_mix();
    int targets[9] = '{4, 64, 64, 16, 0, 40, 64, 8, 30};
    foreach (targets[t])
      for (int i = 0; i < 150; i++) send_request(make_random_req(targets[t]));
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_output_stall();
    rx_hold_request = 300;
    for (int i = 0; i < 40; i++) send_request(make_random_req(32));
  endtask

  // Sender stops until every result is back, then resumes
  task automatic test_pause_for_drain();
    wait_results_drained();
    for (int i = 0; i < 20; i++) send_request(make_random_req(32));
  endtask

  // Neither side idles for a stretch
  task automatic test_no_idle_stretch();
    no_idle = 1'b1;
    for (int i = 0; i < 300; i++) send_request(make_random_req(48));
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    test_edge_cases();
    test_full_store();
    test_random_mix();
    test_output_stall();
    test_pause_for_drain();
    test_no_idle_stretch();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
